>>> rtl/core/jtps_pkg.sv
// shared types and constants for the jump target priority set
`timescale 1ns / 1ps
package jtps_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] MODE_ARM   = 2'd0;
  localparam logic [1:0] MODE_THUMB = 2'd1;
  localparam logic [1:0] MODE_OTHER = 2'd2;

  localparam logic [1:0] ARCH_ARM  = 2'd1;
  localparam logic [1:0] ARCH_MIPS = 2'd2;
  localparam logic [1:0] ARCH_PPC  = 2'd3;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_POPPED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] address;
    logic        address_defined;
    logic [3:0]  target_type;
    logic [1:0]  mode;
    logic [63:0] from_address;
    logic        from_defined;
    logic [31:0] size_value;
    logic        size_defined;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_address;
    logic [3:0]  entry_type;
    logic [1:0]  entry_mode;
    logic [63:0] entry_from;
    logic        entry_from_defined;
    logic [31:0] entry_size;
    logic        entry_size_defined;
    logic [6:0]  entry_count;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] address;
    logic [3:0]  target_type;
    logic [1:0]  mode;
    logic [63:0] from_address;
    logic        from_defined;
    logic [31:0] size_value;
    logic        size_defined;
  } cmd_t;

  // entry record as stored
  typedef struct packed {
    logic [63:0] address;
    logic [63:0] from_address;
    logic [3:0]  target_type;
    logic [1:0]  mode;
    logic        from_defined;
    logic [31:0] size_value;
    logic        size_defined;
  } entry_t;

  // strict less-than on the ordering key; undefined source ranks above defined
  function automatic logic key_less(input entry_t a, input entry_t b);
    logic less;
    if (a.target_type != b.target_type) begin
      less = a.target_type < b.target_type;
    end else if (a.address != b.address) begin
      less = a.address < b.address;
    end else if (a.from_defined != b.from_defined) begin
      less = a.from_defined;
    end else begin
      less = a.from_address < b.from_address;
    end
    return less;
  endfunction

  function automatic logic key_equal(input entry_t a, input entry_t b);
    return (a.target_type == b.target_type) && (a.address == b.address) &&
           (a.from_defined == b.from_defined) && (a.from_address == b.from_address);
  endfunction

endpackage

>>> rtl/core/jtps_front.sv
// front end: normalises and classifies each incoming word
`timescale 1ns / 1ps
module jtps_front
  import jtps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic [1:0] arch_kind,
  output logic     cmd_valid,
  input  logic     cmd_stall,
  output cmd_t     cmd_data
);

  cmd_t cmd_nxt;
  cmd_t cmd_r;
  logic vld_r;
  logic bad;
  logic [63:0] a;
  logic [1:0]  m;

  always_comb begin
    a = in_data.address;
    m = (in_data.mode == 2'd3) ? MODE_OTHER : in_data.mode;
    if (in_data.address_defined && arch_kind == ARCH_ARM && a[0]) begin
      m = MODE_THUMB;
      a[0] = 1'b0;
    end
    bad = !in_data.address_defined ||
          (arch_kind == ARCH_ARM && m == MODE_ARM && a[1:0] != 2'd0) ||
          (arch_kind == ARCH_ARM && m == MODE_THUMB && a[0]) ||
          ((arch_kind == ARCH_MIPS || arch_kind == ARCH_PPC) && a[1:0] != 2'd0);
    cmd_nxt.address      = a;
    cmd_nxt.mode         = m;
    cmd_nxt.target_type  = in_data.target_type;
    cmd_nxt.from_defined = in_data.from_defined;
    cmd_nxt.from_address = in_data.from_defined ? in_data.from_address : 64'd0;
    cmd_nxt.size_defined = in_data.size_defined;
    cmd_nxt.size_value   = in_data.size_defined ? in_data.size_value : 32'd0;
    case (in_data.func)
      FUNC_PUSH: cmd_nxt.op = bad ? OP_REJECT : OP_PUSH;
      FUNC_POP:  cmd_nxt.op = OP_POP;
      default:   cmd_nxt.op = OP_CLEAR;
    endcase
  end

  // single stage register feeding the queue
  assign in_stall  = vld_r && cmd_stall;
  assign cmd_valid = vld_r;
  assign cmd_data  = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

>>> rtl/core/jtps_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps
module jtps_queue
  import jtps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output cmd_t rd_data
);

  cmd_t mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign wr_stall = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

>>> rtl/core/jtps_back.sv
// back end: slot store with one-entry-per-cycle scan for match and minimum
`timescale 1ns / 1ps
module jtps_back
  import jtps_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_t      cmd_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  entry_t mem [CAPACITY];

  logic [2:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [AW-1:0] best_idx_r;
  entry_t        best_r;
  entry_t        rd_r;
  logic          hit_r;
  cmd_t          cmd_r;
  logic          ov_r;
  out_word_t     out_r;
  out_word_t     res_r;
  entry_t        new_e;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign new_e = '{address: cmd_r.address, from_address: cmd_r.from_address,
                   target_type: cmd_r.target_type, mode: cmd_r.mode,
                   from_defined: cmd_r.from_defined, size_value: cmd_r.size_value,
                   size_defined: cmd_r.size_defined};

  assign cmd_stall = st_r != S_IDLE;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // memory read port, data registered
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    if (st_r == S_RD || st_r == S_CMP) rd_en = idx_r < cnt_r;
    if (st_r == S_LAST) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cnt_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_addr];
  end

  function automatic out_word_t report(input logic [2:0] s, input entry_t e,
                                       input logic [CW-1:0] n);
    out_word_t o;
    o.status             = s;
    o.entry_address      = e.address;
    o.entry_type         = e.target_type;
    o.entry_mode         = e.mode;
    o.entry_from         = e.from_address;
    o.entry_from_defined = e.from_defined;
    o.entry_size         = e.size_value;
    o.entry_size_defined = e.size_defined;
    o.entry_count        = 7'(n);
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (ov_r && !out_stall && st_r != S_OUT) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd_data;
            idx_r <= '0;
            hit_r <= 1'b0;
            st_r  <= S_RD;
          end
        end
        S_RD: begin
          // first read issued; decide trivial commands here
          case (cmd_r.op)
            OP_REJECT: begin
              res_r <= report(ST_REJECTED, '0, cnt_r);
              st_r  <= S_OUT;
            end
            OP_CLEAR: begin
              cnt_r <= '0;
              res_r <= report(ST_CLEARED, '0, '0);
              st_r  <= S_OUT;
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                res_r <= report(ST_EMPTY, '0, cnt_r);
                st_r  <= S_OUT;
              end else begin
                idx_r <= idx_r + CW'(1);
                st_r  <= S_CMP;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                mem[0] <= new_e;
                cnt_r  <= CW'(1);
                res_r  <= report(ST_STORED, new_e, CW'(1));
                st_r   <= S_OUT;
              end else begin
                idx_r <= idx_r + CW'(1);
                st_r  <= S_CMP;
              end
            end
          endcase
        end
        S_CMP: begin
          // rd_r holds entry idx_r-1
          if (cmd_r.op == OP_PUSH) begin
            if (!hit_r && key_equal(rd_r, new_e)) begin
              hit_r  <= 1'b1;
              best_r <= rd_r;
            end
          end else if (idx_r == CW'(1) || key_less(rd_r, best_r)) begin
            best_r     <= rd_r;
            best_idx_r <= AW'(idx_r - CW'(1));
          end
          if (idx_r >= cnt_r) begin
            st_r <= (cmd_r.op == OP_POP) ? S_LAST : S_MOVE;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_LAST: begin
          // last entry being read to fill the hole
          st_r <= S_MOVE;
        end
        S_MOVE: begin
          if (cmd_r.op == OP_POP) begin
            mem[best_idx_r] <= rd_r;
            cnt_r <= cnt_r - CW'(1);
            res_r <= report(ST_POPPED, best_r, cnt_r - CW'(1));
          end else if (hit_r) begin
            res_r <= report(ST_DUP, best_r, cnt_r);
          end else if (cnt_r >= CW'(CAPACITY)) begin
            res_r <= report(ST_FULL, '0, cnt_r);
          end else begin
            mem[cnt_r[AW-1:0]] <= new_e;
            cnt_r <= cnt_r + CW'(1);
            res_r <= report(ST_STORED, new_e, cnt_r + CW'(1));
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          // a waiting word keeps its payload until it is taken
          if (!ov_r || !out_stall) begin
            out_r <= res_r;
            ov_r  <= 1'b1;
            st_r  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/jump_target_priority_set.sv
// top level of the jump target priority set
// reject, clear, empty pop and push into an empty set are decided without a scan;
// push and pop with entries held scan them all; the scan reads one entry a cycle
// the back end takes no new word until the result of the last is registered for output
// reset: synchronous active-low, empties the set and sets arch_kind to 0
// slot contents are not cleared by reset, only the entry count
`timescale 1ns / 1ps
module jump_target_priority_set
  import jtps_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  logic [1:0] arch_kind_r;
  logic f_valid, f_stall, q_valid, q_stall;
  cmd_t f_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_kind_r <= 2'd0;
    end else if (cfg_we) begin
      arch_kind_r <= cfg_wdata;
    end
  end

  jtps_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .arch_kind(arch_kind_r),
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd_data(f_data)
  );

  jtps_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall),
    .wr_data(f_data), .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
  );

  jtps_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_stall(q_stall),
    .cmd_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
